[rtl/core/vertical_three_row_sum_top_assert.svh]
// Assertion macros for the vertical three-row sum block
`ifndef VERTICAL_THREE_ROW_SUM_TOP_ASSERT_SVH
`define VERTICAL_THREE_ROW_SUM_TOP_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define VTRS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define VTRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/core/vtrs_pkg.sv]
// Types and constants shared by the vertical three-row sum block
package vtrs_pkg;

	localparam int unsigned DATA_W        = 32;
	localparam int unsigned ROW_CNT_W     = 16;
	localparam int unsigned ROW_COUNT_MIN = 3;
	localparam int unsigned FIRST_OUT_ROW = 2;

	typedef logic [DATA_W-1:0]    word_t;
	typedef logic [ROW_CNT_W-1:0] row_cnt_t;

	typedef struct packed {
		logic emit;
		logic row_end;
		logic frame_end;
	} vtrs_tag_t;

endpackage

[rtl/core/vtrs_cell.sv]
// One word cell of the line buffer shift chain
module vtrs_cell (
	input  logic          clk,
	input  logic          shift,
	input  vtrs_pkg::word_t d,
	output vtrs_pkg::word_t q
);
	import vtrs_pkg::*;

	word_t word_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			word_q <= d;
		end
	end

	assign q = word_q;

endmodule

[rtl/core/vtrs_ctrl.sv]
// Column and row counters with row-end and frame-end marking
module vtrs_ctrl #(
	parameter int unsigned ROW_WIDTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  vtrs_pkg::row_cnt_t   row_count,
	output vtrs_pkg::vtrs_tag_t  tag
);
	import vtrs_pkg::*;

	localparam int unsigned COL_W = (ROW_WIDTH > 1) ? $clog2(ROW_WIDTH) : 1;
	localparam logic [COL_W-1:0] LAST_COL = COL_W'(ROW_WIDTH - 1);

	logic [COL_W-1:0] col_q;
	row_cnt_t         row_q;
	row_cnt_t         rc;
	logic [ROW_CNT_W:0] row_next;
	logic             last_col;
	logic             last_row;

	assign rc       = (row_count < ROW_CNT_W'(ROW_COUNT_MIN)) ? ROW_CNT_W'(ROW_COUNT_MIN)
	                                                          : row_count;
	assign row_next = {1'b0, row_q} + (ROW_CNT_W+1)'(1);
	assign last_col = (col_q == LAST_COL);
	assign last_row = (row_next >= {1'b0, rc});

	assign tag.emit      = (row_q >= ROW_CNT_W'(FIRST_OUT_ROW));
	assign tag.row_end   = last_col;
	assign tag.frame_end = last_col && last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_next[ROW_CNT_W-1:0];
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

endmodule

[rtl/core/vertical_three_row_sum_top.sv]
// Top level of the vertical three-row sum block
//
// Channel | Direction | Beat contents
// s_*     | in        | tdata[31:0] sample
// m_*     | out       | tdata[31:0] sum, tlast row_end, tuser frame_end
// cfg_*   | in        | cfg_data[15:0] row_count
//
// One input beat per cycle while s_tready is high; each result is registered.
// Two line buffers form a shift chain of 2*ROW_WIDTH cells advanced per beat.
// An output register plus a skid register absorb a stall; s_tready drops once skid is full.
// Reset clears counters and valid flags; line buffer contents stay undefined.
module vertical_three_row_sum_top #(
	parameter int unsigned ROW_WIDTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [31:0]          s_tdata,   // [31:0] sample
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [31:0]          m_tdata,   // [31:0] sum
	output logic                 m_tlast,
	output logic                 m_tuser,   // [0] frame_end
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  vtrs_pkg::row_cnt_t   cfg_data
);
	import vtrs_pkg::*;

	`include "vertical_three_row_sum_top_assert.svh"

	localparam int unsigned CHAIN_LEN = 2 * ROW_WIDTH;

	word_t     chain [CHAIN_LEN];
	row_cnt_t  row_count_q;
	vtrs_tag_t tag;
	logic      in_beat;
	logic      new_item;
	word_t     sum;

	logic      out_valid_q, skid_valid_q;
	word_t     out_sum_q, skid_sum_q;
	logic      out_last_q, skid_last_q;
	logic      out_user_q, skid_user_q;
	logic      load_main;

	assign cfg_ready = 1'b1;
	assign s_tready  = !skid_valid_q;
	assign in_beat   = s_tvalid && s_tready;
	assign new_item  = in_beat && tag.emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= ROW_CNT_W'(ROW_COUNT_MIN);
		end else if (cfg_valid && cfg_ready) begin
			row_count_q <= cfg_data;
		end
	end

	vtrs_ctrl #(.ROW_WIDTH(ROW_WIDTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (in_beat),
		.row_count (row_count_q),
		.tag       (tag)
	);

	for (genvar i = 0; i < CHAIN_LEN; i++) begin : g_cell
		if (i == 0) begin : g_head
			vtrs_cell u_cell (.clk(clk), .shift(in_beat), .d(s_tdata), .q(chain[i]));
		end else begin : g_body
			vtrs_cell u_cell (.clk(clk), .shift(in_beat), .d(chain[i-1]), .q(chain[i]));
		end
	end

	assign sum = chain[ROW_WIDTH-1] + chain[CHAIN_LEN-1] + s_tdata;

	assign load_main = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (load_main) begin
			out_valid_q  <= skid_valid_q || new_item;
			skid_valid_q <= 1'b0;
		end else if (new_item) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_main) begin
			if (skid_valid_q) begin
				out_sum_q  <= skid_sum_q;
				out_last_q <= skid_last_q;
				out_user_q <= skid_user_q;
			end else begin
				out_sum_q  <= sum;
				out_last_q <= tag.row_end;
				out_user_q <= tag.frame_end;
			end
		end else if (new_item) begin
			skid_sum_q  <= sum;
			skid_last_q <= tag.row_end;
			skid_user_q <= tag.frame_end;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_sum_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_user_q;

	`VTRS_ASSERT_IMPL(a_frame_end_on_row_end, clk, arst_n, m_tvalid && m_tuser, m_tlast)
	`VTRS_ASSERT_IMPL(a_skid_behind_main, clk, arst_n, skid_valid_q, out_valid_q)
	`VTRS_ASSERT_NEXT(a_skid_fill_on_stall, clk, arst_n, out_valid_q && !m_tready && new_item,
		skid_valid_q)

endmodule

[bench/testbench.sv]
// Self-checking bench for the vertical three-row sum block: directed rows, then random frames
`timescale 1ns / 100ps

module testbench;
	import vtrs_pkg::*;

	localparam int unsigned ROW_WIDTH    = 64;
	localparam int unsigned RANDOM_WORDS = 270;
	localparam int unsigned PLAN_ROWS    = 20;
	localparam int unsigned PRINT_CAP    = 60;

	typedef struct packed {
		word_t sum;
		logic  row_end;
		logic  frame_end;
	} sum_beat_t;

	typedef struct packed {
		bit       do_cfg;
		row_cnt_t cfg;
		word_t    base;
		word_t    step;
		bit       typed;
		word_t    sum;
		bit       fend;
	} row_plan_t;

	logic     clk;
	logic     arst_n;
	logic     s_tvalid;
	logic     s_tready;
	logic [31:0] s_tdata;
	logic     m_tvalid;
	logic     m_tready;
	logic [31:0] m_tdata;
	logic     m_tlast;
	logic     m_tuser;
	logic     cfg_valid;
	logic     cfg_ready;
	row_cnt_t cfg_data;

	vertical_three_row_sum_top #(
		.ROW_WIDTH(ROW_WIDTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	word_t       prev2_row [ROW_WIDTH];
	word_t       prev1_row [ROW_WIDTH];
	int unsigned col_pos;
	row_cnt_t    row_pos;
	row_cnt_t    rows_per_frame;

	sum_beat_t   pending_sums [$];
	row_plan_t   plan_rows [PLAN_ROWS];
	int unsigned errors;
	bit          quiet;
	int unsigned stall_left;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#10ms;
		$display("FAIL vertical_three_row_sum_top");
		$finish;
	end

	task automatic flag_mismatch(input string what);
		if (errors < PRINT_CAP)
			$display("%0t mismatch: %s", $time, what);
		errors++;
	endtask

	function automatic bit column_sum_step(input word_t w, output sum_beat_t res);
		int unsigned rc;
		int unsigned c;
		bit          last_col;
		bit          last_row;
		bit          emit;
		rc = (32'(rows_per_frame) < ROW_COUNT_MIN) ? ROW_COUNT_MIN : 32'(rows_per_frame);
		c = (col_pos >= ROW_WIDTH) ? 0 : col_pos;
		last_col = (c == ROW_WIDTH - 1);
		last_row = (int'(row_pos) + 1 >= rc);
		emit = (row_pos >= row_cnt_t'(FIRST_OUT_ROW));
		res.sum = prev2_row[c] + prev1_row[c] + w;
		res.row_end = last_col;
		res.frame_end = last_col && last_row;
		prev2_row[c] = prev1_row[c];
		prev1_row[c] = w;
		if (last_col) begin
			col_pos = 0;
			row_pos = last_row ? '0 : row_pos + row_cnt_t'(1);
		end else begin
			col_pos = c + 1;
		end
		return emit;
	endfunction

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic word_t pick_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 32'h8000_0000;
			3: return word_t'(1) << $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_word(input word_t w, input bit typed, input word_t tsum, input bit tfend);
		int unsigned gap;
		int unsigned c;
		sum_beat_t   res;
		gap = idle_len();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= w;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		c = col_pos;
		if (column_sum_step(w, res)) begin
			if (typed) begin
				res.sum = tsum;
				res.row_end = (c == ROW_WIDTH - 1);
				res.frame_end = res.row_end && tfend;
			end
			pending_sums.push_back(res);
		end
	endtask

	// hold the sender until every result is out, then let the pipeline settle
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_sums.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_row_count(input row_cnt_t v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		rows_per_frame = v;
	endtask

	always @(posedge clk) begin
		sum_beat_t want;
		int unsigned r;
		if (arst_n && m_tvalid === 1'b1 && m_tready) begin
			if (pending_sums.size() == 0) begin
				flag_mismatch($sformatf("unexpected beat sum=%h", m_tdata));
			end else begin
				want = pending_sums.pop_front();
				if (m_tdata !== want.sum)
					flag_mismatch($sformatf("sum %h, want %h", m_tdata, want.sum));
				if (m_tlast !== want.row_end)
					flag_mismatch($sformatf("row_end %b, want %b", m_tlast, want.row_end));
				if (m_tuser !== want.frame_end)
					flag_mismatch($sformatf("frame_end %b, want %b", m_tuser,
						want.frame_end));
			end
		end
		if (quiet) begin
			stall_left <= 0;
			m_tready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else begin
			r = $urandom_range(0, 99);
			if (r < 75) begin
				m_tready <= 1'b1;
			end else begin
				stall_left <= (r < 96) ? $urandom_range(0, 2) : $urandom_range(8, 30);
				m_tready <= 1'b0;
			end
		end
	end

	initial begin
		int unsigned random_sent;
		int unsigned n;
		row_cnt_t    rc;
		quiet = 1'b0;
		col_pos = 0;
		row_pos = '0;
		rows_per_frame = row_cnt_t'(ROW_COUNT_MIN);
		for (int i = 0; i < ROW_WIDTH; i++) begin
			prev2_row[i] = '0;
			prev1_row[i] = '0;
		end
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;

		plan_rows = '{
			'{1'b0, 16'd0,     32'hFFFF_FFFF, 32'h0,         1'b0, 32'h0,         1'b0},
			'{1'b0, 16'd0,     32'hFFFF_FFFF, 32'h0,         1'b0, 32'h0,         1'b0},
			'{1'b0, 16'd0,     32'hFFFF_FFFF, 32'h0,         1'b1, 32'hFFFF_FFFD, 1'b1},
			'{1'b0, 16'd0,     32'h0,         32'h0,         1'b0, 32'h0,         1'b0},
			'{1'b0, 16'd0,     32'h0,         32'h0,         1'b0, 32'h0,         1'b0},
			'{1'b0, 16'd0,     32'h0,         32'h0,         1'b1, 32'h0,         1'b1},
			'{1'b1, 16'd0,     32'h8000_0000, 32'h0,         1'b0, 32'h0,         1'b0},
			'{1'b0, 16'd0,     32'h8000_0000, 32'h0,         1'b0, 32'h0,         1'b0},
			'{1'b0, 16'd0,     32'h0000_0001, 32'h0,         1'b1, 32'h0000_0001, 1'b1},
			'{1'b1, 16'd2,     32'h0000_0001, 32'h1,         1'b0, 32'h0,         1'b0},
			'{1'b0, 16'd0,     32'h7FFF_FFFF, 32'h3,         1'b0, 32'h0,         1'b0},
			'{1'b0, 16'd0,     32'hFFFF_FF00, 32'h5,         1'b0, 32'h0,         1'b0},
			'{1'b1, 16'd4,     32'h1234_5678, 32'h0101_0101, 1'b0, 32'h0,         1'b0},
			'{1'b0, 16'd0,     32'hA5A5_A5A5, 32'h0F0F_0F0F, 1'b0, 32'h0,         1'b0},
			'{1'b0, 16'd0,     32'h5A5A_5A5A, 32'hFFFF_FFFF, 1'b0, 32'h0,         1'b0},
			'{1'b0, 16'd0,     32'hDEAD_BEEF, 32'h7,         1'b0, 32'h0,         1'b0},
			'{1'b1, 16'hFFFF,  32'h1,         32'h0,         1'b0, 32'h0,         1'b0},
			'{1'b0, 16'd0,     32'h2,         32'h0,         1'b0, 32'h0,         1'b0},
			'{1'b0, 16'd0,     32'h4,         32'h0,         1'b1, 32'h7,         1'b0},
			'{1'b1, 16'd3,     32'h8,         32'h0,         1'b1, 32'hE,         1'b1}
		};

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan_rows[i]) begin
			if (plan_rows[i].do_cfg)
				write_row_count(plan_rows[i].cfg);
			quiet = ($urandom_range(0, 3) == 0);
			for (int c = 0; c < ROW_WIDTH; c++)
				send_word(plan_rows[i].base + plan_rows[i].step * c, plan_rows[i].typed,
					plan_rows[i].sum, plan_rows[i].fend);
		end

		random_sent = 0;
		while (random_sent < RANDOM_WORDS) begin
			case ($urandom_range(0, 9))
				0: rc = row_cnt_t'($urandom_range(0, 2));
				1: rc = 16'hFFFF;
				2: rc = row_cnt_t'($urandom_range(6, 65534));
				default: rc = row_cnt_t'($urandom_range(3, 5));
			endcase
			write_row_count(rc);
			quiet = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 3) == 0)
				n = $urandom_range(1, 150);
			else
				n = ROW_WIDTH * $urandom_range(1, 4);
			if (n > RANDOM_WORDS - random_sent)
				n = RANDOM_WORDS - random_sent;
			repeat (n) send_word(pick_word(), 1'b0, '0, 1'b0);
			random_sent += n;
		end

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("PASS vertical_three_row_sum_top");
		else
			$display("FAIL vertical_three_row_sum_top");
		$finish;
	end

endmodule
